@@ rtl/nfbt_pkg.sv @@
// ----------------------------------------------------------------------------
// nfbt_pkg: shared types and constants of the nearest-five selector
// Slot type, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package nfbt_pkg;

	localparam int DATA_W         = 32;
	localparam int DIST_W         = 33;
	localparam int KEEP_COUNT_DEF = 5;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BELOW_MODE = 2'd1;

	// One slot of the store. A distance of zero marks an empty slot.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic        [DIST_W-1:0] distance;
	} slot_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic insert;
		logic clear;
	} cell_ctrl_t;

endpackage : nfbt_pkg

`default_nettype wire

@@ rtl/nfbt_cell.sv @@
// ----------------------------------------------------------------------------
// nfbt_cell: one slot of the sorted insertion row
// Holds one kept sample and its distance, takes the new sample or its left
// neighbor's slot when an insertion lands at or before it.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  nfbt_pkg::cell_ctrl_t ctrl,
	input  nfbt_pkg::slot_t     incoming,
	input  nfbt_pkg::slot_t     left_slot,
	input  logic                left_take,
	output logic                take,
	output nfbt_pkg::slot_t     slot,
	output nfbt_pkg::slot_t     slot_next
);
	import nfbt_pkg::*;

	slot_t slot_q;

	// Insertion lands here when this slot is empty or strictly farther away.
	assign take = ctrl.insert &&
		((slot_q.distance == '0) || (slot_q.distance > incoming.distance));

	always_comb begin
		if (take && left_take) begin
			slot_next = left_slot;
		end else if (take) begin
			slot_next = incoming;
		end else begin
			slot_next = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.clear) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_next;
		end
	end

	assign slot = slot_q;

endmodule : nfbt_cell

`default_nettype wire

@@ rtl/nfbt_unload.sv @@
// ----------------------------------------------------------------------------
// nfbt_unload: result shift chain
// Captures a full snapshot of the row and shifts it out one value per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbt_unload #(
	parameter int KEEP_COUNT = nfbt_pkg::KEEP_COUNT_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            load,
	input  logic [KEEP_COUNT-1:0][nfbt_pkg::DATA_W-1:0]     load_values,
	output logic                                            can_load,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	output logic [nfbt_pkg::DATA_W-1:0]                     m_tdata,
	output logic                                            m_tlast
);
	import nfbt_pkg::*;

	localparam int CNT_W = $clog2(KEEP_COUNT + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(KEEP_COUNT);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	logic [KEEP_COUNT-1:0][DATA_W-1:0] vals_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              pop;

	assign m_tvalid = (cnt_q != '0);
	assign m_tlast  = (cnt_q == ONE_CNT);
	assign m_tdata  = vals_q[0];
	assign pop      = m_tvalid && m_tready;
	assign can_load = (cnt_q == '0) || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= FULL_CNT;
		end else if (pop) begin
			cnt_q <= cnt_q - ONE_CNT;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vals_q <= load_values;
		end else if (pop) begin
			for (int i = 0; i < KEEP_COUNT - 1; i++) begin
				vals_q[i] <= vals_q[i+1];
			end
		end
	end

endmodule : nfbt_unload

`default_nettype wire

@@ rtl/nearest_five_beyond_threshold.sv @@
// ----------------------------------------------------------------------------
// nearest_five_beyond_threshold: top-k nearest selector beyond a threshold
// Keeps the KEEP_COUNT samples closest to the threshold on one side of it,
// and emits them nearest first at the end of each set.
// ----------------------------------------------------------------------------
// Usage: samples enter on the s_ stream, one per transfer, with s_tlast on
// the final sample of a set. Samples strictly above the threshold (or
// strictly below it when below_mode is 1) are sorted into a row of
// KEEP_COUNT cells by ascending distance; ties keep the earlier sample.
// After the last sample of a set the row is copied into an output chain and
// cleared, and KEEP_COUNT results leave on the m_ stream, nearest first,
// with 0 for an empty slot and m_tlast on the final one.
// Throughput is one sample per cycle while the row does not wait. A sample is
// held in the distance register and then enters the row; with an empty output
// chain the first result of a set is valid once its last sample has left the
// distance register and the output chain has loaded the snapshot. The row
// only waits when a set's last sample meets an output chain still holding
// the previous set, so back-to-back short sets are paced by the output
// chain draining one value per transfer.
// Reset clears the row, the output chain and the registers (threshold 0,
// above mode). A stalled receiver holds its result; the input keeps flowing
// until a last sample has to wait for the chain to empty.
// Configuration writes are always accepted and are meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_five_beyond_threshold #(
	parameter int KEEP_COUNT = nfbt_pkg::KEEP_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Sample stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [nfbt_pkg::DATA_W-1:0]      s_tdata,   // [31:0] sample
	input  logic                             s_tlast,   // last_sample
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nfbt_pkg::DATA_W-1:0]      m_tdata,   // [31:0] kept_value
	output logic                             m_tlast,   // last_result
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nfbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nfbt_pkg::DATA_W-1:0]      cfg_data
);
	import nfbt_pkg::*;

	// Configuration registers.
	logic signed [DATA_W-1:0] threshold_q;
	logic                     below_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			below_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD:  threshold_q  <= cfg_data;
				REG_BELOW_MODE: below_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: distance to the threshold and the side test. Both differences
	// are formed in 33 bits in parallel, so neither can wrap.
	logic [DIST_W-1:0] diff_above;
	logic [DIST_W-1:0] diff_below;
	logic              beyond;

	assign diff_above = {s_tdata[DATA_W-1], s_tdata} - {threshold_q[DATA_W-1], threshold_q};
	assign diff_below = {threshold_q[DATA_W-1], threshold_q} - {s_tdata[DATA_W-1], s_tdata};
	assign beyond     = below_mode_q ? (!diff_below[DIST_W-1] && (diff_below != '0))
	                                 : (!diff_above[DIST_W-1] && (diff_above != '0));

	logic              valid_s1;
	logic              keep_s1;
	logic              last_s1;
	slot_t             sample_s1;
	logic              advance;
	logic              can_load;

	// A set's last sample moves on only when the output chain can take the
	// snapshot in the same cycle.
	assign advance  = valid_s1 && !(last_s1 && !can_load);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			keep_s1            <= beyond;
			last_s1            <= s_tlast;
			sample_s1.value    <= s_tdata;
			sample_s1.distance <= below_mode_q ? diff_below : diff_above;
		end
	end

	// Stage 2: the insertion row. Every cell compares against the same new
	// sample; the first cell that takes it loads it, the ones after it load
	// their left neighbor, and the rightmost slot falls off.
	cell_ctrl_t ctrl;

	assign ctrl.insert = advance && keep_s1;
	assign ctrl.clear  = advance && last_s1;

	slot_t [KEEP_COUNT-1:0]             row_slot;
	slot_t [KEEP_COUNT-1:0]             row_next;
	logic  [KEEP_COUNT-1:0]             row_take;
	logic  [KEEP_COUNT-1:0][DATA_W-1:0] snap_values;

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_row
		slot_t left_slot;
		logic  left_take;

		if (i == 0) begin : g_head
			assign left_slot = '0;
			assign left_take = 1'b0;
		end else begin : g_body
			assign left_slot = row_slot[i-1];
			assign left_take = row_take[i-1];
		end

		nfbt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.incoming  (sample_s1),
			.left_slot (left_slot),
			.left_take (left_take),
			.take      (row_take[i]),
			.slot      (row_slot[i]),
			.slot_next (row_next[i])
		);

		assign snap_values[i] = row_next[i].value;
	end

	// Output chain: loaded with the row as it stands after the last sample.
	nfbt_unload #(
		.KEEP_COUNT (KEEP_COUNT)
	) u_unload (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (ctrl.clear),
		.load_values (snap_values),
		.can_load    (can_load),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	// The stage-1 register only stalls on a last sample facing a busy chain.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (last_s1 && m_tvalid))
		else $error("sample stage stalled without a pending set in the output chain");

	// A result group, once started, is not cut short before its final value.
	a_group_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("result group ended before its final value");

	// Occupied slots stay packed at the front and sorted by distance.
	for (genvar i = 1; i < KEEP_COUNT; i++) begin : g_sorted
		a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
			(row_slot[i].distance != '0) |->
			((row_slot[i-1].distance != '0) &&
			 (row_slot[i-1].distance <= row_slot[i].distance)))
			else $error("insertion row out of order");
	end

endmodule : nearest_five_beyond_threshold

`default_nettype wire
